### src/rcfd_pkg.sv
`timescale 1ns / 1ps

package rcfd_pkg;

    // Frame geometry
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
    localparam int CHANNEL_COUNT = 16;
    localparam int CHANNEL_BITS  = 11;
    localparam int CHANNEL_IDX_W = $clog2(CHANNEL_COUNT);

    // Byte positions inside a frame; position zero means hunting for sync.
    localparam logic [4:0] POS_HUNT      = 5'd0;
    localparam logic [4:0] POS_LENGTH    = 5'd1;
    localparam logic [4:0] POS_TYPE      = 5'd2;
    localparam logic [4:0] POS_PAYLOAD0  = 5'd3;
    localparam logic [4:0] POS_CRC       = 5'd25;

    localparam logic [7:0] GOOD_LENGTH   = 8'd24;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_VALUE = 2'd0;
    localparam logic [1:0] CFG_FRAME_KIND = 2'd1;
    localparam logic [1:0] CFG_CRC_POLY   = 2'd2;

    localparam logic [7:0] SYNC_RESET = 8'hC8;
    localparam logic [7:0] KIND_RESET = 8'd22;
    localparam logic [7:0] POLY_RESET = 8'hD5;

    // One finished frame handed from the front to the back.
    typedef struct packed {
        logic                    good;
        logic [PAYLOAD_BITS-1:0] payload;
    } frame_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // CRC-8, MSB first, one byte per call.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

### src/rcfd_front.sv
`timescale 1ns / 1ps

module rcfd_front
    import rcfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic [7:0]    rx_byte,
    input  logic          in_valid,
    output logic          in_stall,
    input  queue_status_t q_status,
    output logic          q_push,
    output frame_t        q_entry
);

    logic [7:0]              sync_reg;
    logic [7:0]              kind_reg;
    logic [7:0]              poly_reg;
    logic [4:0]              pos_reg;
    logic [7:0]              length_reg;
    logic [7:0]              type_reg;
    logic [7:0]              crc_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    logic       accept;
    logic [7:0] crc_next;
    logic       in_payload;

    // Only the CRC byte needs room in the queue.
    assign in_stall   = (pos_reg == POS_CRC) && q_status.full;
    assign accept     = in_valid && !in_stall;
    assign crc_next   = crc8_feed(crc_reg, rx_byte, poly_reg);
    assign in_payload = (pos_reg >= POS_PAYLOAD0) && (pos_reg < POS_CRC);

    // Frame judgment on the CRC byte.
    assign q_push          = accept && (pos_reg == POS_CRC);
    assign q_entry.good    = (type_reg == kind_reg) && (length_reg == GOOD_LENGTH)
                             && (crc_reg == rx_byte);
    assign q_entry.payload = payload_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sync_reg <= SYNC_RESET;
            kind_reg <= KIND_RESET;
            poly_reg <= POLY_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SYNC_VALUE: sync_reg <= cfg_data;
                CFG_FRAME_KIND: kind_reg <= cfg_data;
                CFG_CRC_POLY:   poly_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame position, header bytes and running CRC.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg    <= POS_HUNT;
            length_reg <= 8'd0;
            type_reg   <= 8'd0;
            crc_reg    <= 8'd0;
        end else if (accept) begin
            if (pos_reg == POS_HUNT) begin
                if (rx_byte == sync_reg) begin
                    pos_reg <= POS_LENGTH;
                    crc_reg <= 8'd0;
                end
            end else if (pos_reg == POS_LENGTH) begin
                length_reg <= rx_byte;
                pos_reg    <= POS_TYPE;
            end else if (pos_reg == POS_TYPE) begin
                type_reg <= rx_byte;
                crc_reg  <= crc_next;
                pos_reg  <= POS_PAYLOAD0;
            end else if (in_payload) begin
                crc_reg <= crc_next;
                pos_reg <= pos_reg + 5'd1;
            end else begin
                pos_reg <= POS_HUNT;
            end
        end
    end

    // Payload shift line: the first payload byte ends at the low end.
    always_ff @(posedge clk) begin
        if (accept && in_payload) begin
            payload_reg <= {rx_byte, payload_reg[PAYLOAD_BITS-1:8]};
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CRC)
        else $error("frame position out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("frame pushed into a full queue");

endmodule

### src/rcfd_queue.sv
`timescale 1ns / 1ps

module rcfd_queue
    import rcfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_t        push_entry,
    input  logic          pop,
    output frame_t        head_entry,
    output queue_status_t status
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head_entry   = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from an empty queue");

endmodule

### src/rcfd_back.sv
`timescale 1ns / 1ps

module rcfd_back
    import rcfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  frame_t                   head_entry,
    input  queue_status_t            q_status,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CHANNEL_IDX_W-1:0] channel_index,
    output logic [CHANNEL_BITS-1:0]  channel_value,
    output logic                     link_status,
    output logic                     last
);

    logic                     busy_reg;
    logic                     good_reg;
    logic [PAYLOAD_BITS-1:0]  payload_reg;
    logic [CHANNEL_IDX_W-1:0] ch_reg;
    logic                     out_valid_reg;
    logic [CHANNEL_IDX_W-1:0] index_reg;
    logic [CHANNEL_BITS-1:0]  value_reg;
    logic                     status_reg;
    logic                     last_reg;

    logic advance;
    logic final_ch;

    assign q_pop    = !busy_reg && !q_status.empty;
    assign advance  = busy_reg && (!out_valid_reg || !out_stall);
    assign final_ch = (ch_reg == CHANNEL_IDX_W'(CHANNEL_COUNT - 1));

    assign out_valid     = out_valid_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign link_status   = status_reg;
    assign last          = last_reg;

    // Frame sequencer: one result per cycle into the output register unless the output is stalled.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            good_reg      <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                good_reg <= head_entry.good;
                ch_reg   <= '0;
            end else if (advance) begin
                ch_reg <= ch_reg + 1'b1;
                if (!good_reg || final_ch) begin
                    busy_reg <= 1'b0;
                end
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and result fields; channels leave from the low end, 11 bits a step.
    always_ff @(posedge clk) begin
        if (q_pop) begin
            payload_reg <= head_entry.payload;
        end else if (advance) begin
            payload_reg <= payload_reg >> CHANNEL_BITS;
        end
        if (advance) begin
            if (good_reg) begin
                index_reg  <= ch_reg;
                value_reg  <= payload_reg[CHANNEL_BITS-1:0];
                status_reg <= 1'b0;
                last_reg   <= final_ch;
            end else begin
                index_reg  <= '0;
                value_reg  <= '0;
                status_reg <= 1'b1;
                last_reg   <= 1'b1;
            end
        end
    end

    a_failsafe_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> last_reg && (index_reg == '0) && (value_reg == '0))
        else $error("failsafe result malformed");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !status_reg |->
            (last_reg == (index_reg == CHANNEL_IDX_W'(CHANNEL_COUNT - 1))))
        else $error("last flag does not match final channel");

endmodule

### src/rc_channel_frame_decoder_core.sv
`timescale 1ns / 1ps
// The CRC byte pushes its frame into the queue; the sequencer pops it and then registers the first result.
// Throughput: one byte per cycle while in_stall is low; a frame drains one result per cycle
// (16 or 1 results) while out_stall is low, once it has been taken from the queue.
// A two-entry frame queue sits between the byte front and the result sequencer;
// input stalls only on a CRC byte while that queue is full.
// Reset (asynchronous, active low) returns to sync hunting and restores register defaults.

module rc_channel_frame_decoder_core
    import rcfd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [7:0]               cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               rx_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CHANNEL_IDX_W-1:0] channel_index,
    output logic [CHANNEL_BITS-1:0]  channel_value,
    output logic                     link_status,
    output logic                     last
);

    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;
    frame_t        q_entry;
    frame_t        head_entry;

    // Byte front: hunting, header capture, CRC and payload collection.
    rcfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (rx_byte),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // Frame queue between front and back.
    rcfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    // Result sequencer: channel unpacking or failsafe.
    rcfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .q_status      (q_status),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .link_status   (link_status),
        .last          (last)
    );

endmodule
